// ===== hw/rtl/pst_pkg.sv =====
// Shared types and constants for the priority-sorted handle table.
`timescale 1ns / 1ps
package pst_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int MODE_W      = 2;
  localparam int HANDLE_W    = 8;
  localparam int PRI_W       = 8;
  localparam int STATUS_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_ACTIVE = 2'd2,
    MODE_MAIN   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRI_W-1:0]    pri;
  } slot_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    slot_t             data;
  } slot_wr_t;

  typedef struct packed {
    status_t             status;
    logic [CNT_W-1:0]    entry_count;
    logic                main_valid;
    logic [HANDLE_W-1:0] main_handle;
    logic                active_valid;
    logic [HANDLE_W-1:0] active_handle;
  } result_t;

endpackage

// ===== hw/rtl/pst_if.sv =====
// Valid/ready channel interfaces for requests and results of the handle table.
`timescale 1ns / 1ps
interface pst_in_if import pst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [HANDLE_W-1:0] handle;
  logic [PRI_W-1:0]    priority_req;

  modport source (output valid, mode, handle, priority_req, input ready);
  modport sink   (input valid, mode, handle, priority_req, output ready);
endinterface

interface pst_out_if import pst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    entry_count;
  logic                main_valid;
  logic [HANDLE_W-1:0] main_handle;
  logic                active_valid;
  logic [HANDLE_W-1:0] active_handle;

  modport source (output valid, status, entry_count, main_valid, main_handle,
                  active_valid, active_handle, input ready);
  modport sink   (input valid, status, entry_count, main_valid, main_handle,
                  active_valid, active_handle, output ready);
endinterface

// ===== hw/rtl/pst_store.sv =====
// Slot memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module pst_store import pst_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_t            rd_data_r,
  input  slot_wr_t         wr
);

  slot_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/pst_engine.sv =====
// Sequencer that scans, shifts and updates the sorted table one slot per cycle.
`timescale 1ns / 1ps
module pst_engine import pst_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [MODE_W-1:0]   req_mode,
  input  logic [HANDLE_W-1:0] req_handle,
  input  logic [PRI_W-1:0]    req_pri,
  output logic [IDX_W-1:0]    rd_addr,
  input  slot_t               rd_data,
  output slot_wr_t            wr,
  output logic                res_valid,
  input  logic                res_ready,
  output result_t             res
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_PLACE  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t              state_r;
  mode_t               mode_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [PRI_W-1:0]    pri_r;
  status_t             status_r;
  logic [CNT_W-1:0]    count_r;
  logic [HANDLE_W-1:0] main_id_r;
  logic                main_set_r;
  logic [HANDLE_W-1:0] active_id_r;
  logic                active_set_r;
  logic [CNT_W-1:0]    rd_ptr_r;
  logic                pend_r;
  logic [CNT_W-1:0]    cmp_idx_r;
  logic                found_r;
  logic [CNT_W-1:0]    hit_pos_r;
  logic                pos_found_r;
  logic [CNT_W-1:0]    ins_pos_r;
  logic [CNT_W-1:0]    place_pos_r;
  logic [CNT_W-1:0]    mv_r;
  logic [HANDLE_W-1:0] head0_r;
  logic [HANDLE_W-1:0] head1_r;

  logic issue;
  logic scan_done;
  logic shift_done;

  assign issue = ((state_r == S_SCAN) && (rd_ptr_r != count_r)) ||
                 ((state_r == S_SHIFT) && (mv_r != '0));
  assign scan_done  = (rd_ptr_r == count_r) && !pend_r;
  assign shift_done = (mv_r == '0) && !pend_r;
  assign rd_addr    = rd_ptr_r[IDX_W-1:0];

  // Insert moves entries one place up, remove one place down.
  always_comb begin
    wr = '0;
    if ((state_r == S_SHIFT) && pend_r) begin
      wr.en   = 1'b1;
      wr.data = rd_data;
      if (mode_r == MODE_INSERT) begin
        wr.addr = cmp_idx_r[IDX_W-1:0] + IDX_W'(1);
      end else begin
        wr.addr = cmp_idx_r[IDX_W-1:0] - IDX_W'(1);
      end
    end else if (state_r == S_PLACE) begin
      wr.en          = 1'b1;
      wr.addr        = place_pos_r[IDX_W-1:0];
      wr.data.handle = handle_r;
      wr.data.pri    = pri_r;
    end
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FINISH);

  always_comb begin
    res.status        = status_r;
    res.entry_count   = count_r;
    res.main_valid    = main_set_r;
    res.main_handle   = main_id_r;
    res.active_valid  = active_set_r;
    res.active_handle = active_id_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      main_id_r    <= '0;
      main_set_r   <= 1'b0;
      active_id_r  <= '0;
      active_set_r <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      pend_r    <= issue;
      cmp_idx_r <= rd_ptr_r;
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            mode_r      <= mode_t'(req_mode);
            handle_r    <= req_handle;
            pri_r       <= req_pri;
            status_r    <= ST_DONE;
            found_r     <= 1'b0;
            pos_found_r <= 1'b0;
            rd_ptr_r    <= '0;
            case (mode_t'(req_mode))
              MODE_ACTIVE: begin
                active_id_r  <= req_handle;
                active_set_r <= 1'b1;
                state_r      <= S_FINISH;
              end
              MODE_MAIN: begin
                main_id_r  <= req_handle;
                main_set_r <= 1'b1;
                state_r    <= S_FINISH;
              end
              default: begin
                state_r <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_ptr_r <= rd_ptr_r + CNT_W'(1);
          end
          // The shared comparator looks at the slot read in the previous cycle.
          if (pend_r) begin
            if (!found_r && (rd_data.handle == handle_r)) begin
              found_r   <= 1'b1;
              hit_pos_r <= cmp_idx_r;
            end
            if (!pos_found_r && (pri_r < rd_data.pri)) begin
              pos_found_r <= 1'b1;
              ins_pos_r   <= cmp_idx_r;
            end
            if (cmp_idx_r == CNT_W'(0)) begin
              head0_r <= rd_data.handle;
            end
            if (cmp_idx_r == CNT_W'(1)) begin
              head1_r <= rd_data.handle;
            end
          end
          if (scan_done) begin
            if (mode_r == MODE_INSERT) begin
              if (found_r) begin
                status_r <= ST_DUP;
                state_r  <= S_FINISH;
              end else if (count_r == CNT_W'(MAX_ENTRIES)) begin
                status_r <= ST_FULL;
                state_r  <= S_FINISH;
              end else begin
                place_pos_r <= pos_found_r ? ins_pos_r : count_r;
                mv_r        <= count_r - (pos_found_r ? ins_pos_r : count_r);
                rd_ptr_r    <= count_r - CNT_W'(1);
                state_r     <= S_SHIFT;
              end
            end else begin
              if (!found_r) begin
                status_r <= ST_NOTFOUND;
                state_r  <= S_FINISH;
              end else begin
                place_pos_r <= hit_pos_r;
                mv_r        <= count_r - CNT_W'(1) - hit_pos_r;
                rd_ptr_r    <= hit_pos_r + CNT_W'(1);
                state_r     <= S_SHIFT;
              end
            end
          end
        end
        S_SHIFT: begin
          if (issue) begin
            mv_r <= mv_r - CNT_W'(1);
            if (mode_r == MODE_INSERT) begin
              rd_ptr_r <= rd_ptr_r - CNT_W'(1);
            end else begin
              rd_ptr_r <= rd_ptr_r + CNT_W'(1);
            end
          end
          if (shift_done) begin
            if (mode_r == MODE_INSERT) begin
              state_r <= S_PLACE;
            end else begin
              count_r <= count_r - CNT_W'(1);
              if (main_set_r && (main_id_r == handle_r)) begin
                if (count_r != CNT_W'(1)) begin
                  // The new head is the old second entry if the head itself went.
                  main_id_r <= (place_pos_r == CNT_W'(0)) ? head1_r : head0_r;
                end else begin
                  main_id_r  <= '0;
                  main_set_r <= 1'b0;
                end
              end
              if (active_set_r && (active_id_r == handle_r)) begin
                active_id_r  <= '0;
                active_set_r <= 1'b0;
              end
              state_r <= S_FINISH;
            end
          end
        end
        S_PLACE: begin
          count_r <= count_r + CNT_W'(1);
          if (count_r == '0) begin
            main_id_r  <= handle_r;
            main_set_r <= 1'b1;
          end
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/priority_sorted_handle_table.sv =====
// Top level of the priority-sorted handle table with its result register.
`timescale 1ns / 1ps
// The block holds up to MAX_ENTRIES handles sorted by ascending priority, plus
// a main and an active handle, and serves insert, remove, set-active and
// set-main requests, each answered by one result transfer. Requests are
// handled one at a time by a sequencer with a single comparator walking a
// one-read, one-write slot memory. A set-active or set-main result passes from
// the engine's finish state through the output register. An insert or remove
// scans the entries held; if it succeeds, it then shifts the slots past the
// affected position and, for an insert, writes the new entry. The next request
// is taken while a result still waits in the output register; a second
// finished result waits in the engine.
module priority_sorted_handle_table import pst_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  pst_in_if.sink    in_ch,
  pst_out_if.source out_ch
);

  logic [IDX_W-1:0] rd_addr;
  slot_t            rd_data;
  slot_wr_t         wr;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid_r;
  result_t          out_res_r;

  pst_store u_store (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data),
    .wr        (wr)
  );

  pst_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_ch.valid),
    .req_ready  (in_ch.ready),
    .req_mode   (in_ch.mode),
    .req_handle (in_ch.handle),
    .req_pri    (in_ch.priority_req),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr         (wr),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.entry_count   = out_res_r.entry_count;
  assign out_ch.main_valid    = out_res_r.main_valid;
  assign out_ch.main_handle   = out_res_r.main_handle;
  assign out_ch.active_valid  = out_res_r.active_valid;
  assign out_ch.active_handle = out_res_r.active_handle;

endmodule

// ===== tb/priority_sorted_handle_table_test.sv =====
// Self-checking testbench for the priority-sorted handle table.
`timescale 1ns / 1ps
module priority_sorted_handle_table_test;
  import pst_pkg::*;

  // Shadow copy of the table that predicts each result and checks it against the block.
  class handle_table_shadow;
    logic [HANDLE_W-1:0] slot_handle [MAX_ENTRIES];
    logic [PRI_W-1:0]    slot_pri [MAX_ENTRIES];
    int unsigned         held;
    logic                main_on;
    logic [HANDLE_W-1:0] main_id;
    logic                active_on;
    logic [HANDLE_W-1:0] active_id;
    result_t             pending_results[$];
    int unsigned         errors;

    function new();
      held      = 0;
      main_on   = 1'b0;
      main_id   = '0;
      active_on = 1'b0;
      active_id = '0;
      errors    = 0;
    endfunction

    function int unsigned locate(logic [HANDLE_W-1:0] h);
      int unsigned i;
      for (i = 0; i < held; i++) begin
        if (slot_handle[i] == h) return i;
      end
      return held;
    endfunction

    function void accept_request(mode_t m, logic [HANDLE_W-1:0] h, logic [PRI_W-1:0] p);
      int unsigned pos;
      int unsigned i;
      status_t     st;
      result_t     r;
      st = ST_DONE;
      case (m)
        MODE_INSERT: begin
          // The duplicate check takes precedence over the full check.
          if (locate(h) < held) begin
            st = ST_DUP;
          end else if (held >= MAX_ENTRIES) begin
            st = ST_FULL;
          end else begin
            if (held == 0) begin
              main_on = 1'b1;
              main_id = h;
            end
            pos = held;
            for (i = 0; i < held; i++) begin
              if (p < slot_pri[i]) begin
                pos = i;
                break;
              end
            end
            for (i = held; i > pos; i--) begin
              slot_handle[i] = slot_handle[i-1];
              slot_pri[i]    = slot_pri[i-1];
            end
            slot_handle[pos] = h;
            slot_pri[pos]    = p;
            held++;
          end
        end
        MODE_REMOVE: begin
          pos = locate(h);
          if (pos >= held) begin
            st = ST_NOTFOUND;
          end else begin
            for (i = pos; i + 1 < held; i++) begin
              slot_handle[i] = slot_handle[i+1];
              slot_pri[i]    = slot_pri[i+1];
            end
            held--;
            if (main_on && main_id == h) begin
              if (held > 0) begin
                main_id = slot_handle[0];
              end else begin
                main_on = 1'b0;
                main_id = '0;
              end
            end
            if (active_on && active_id == h) begin
              active_on = 1'b0;
              active_id = '0;
            end
          end
        end
        MODE_ACTIVE: begin
          active_on = 1'b1;
          active_id = h;
        end
        default: begin
          main_on = 1'b1;
          main_id = h;
        end
      endcase
      r.status        = st;
      r.entry_count   = CNT_W'(held);
      r.main_valid    = main_on;
      r.main_handle   = main_on ? main_id : '0;
      r.active_valid  = active_on;
      r.active_handle = active_on ? active_id : '0;
      pending_results = {pending_results, r};
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, got %p", $time, got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      compare_field("status", 8'(exp.status), 8'(got.status));
      compare_field("entry_count", 8'(exp.entry_count), 8'(got.entry_count));
      compare_field("main_valid", 8'(exp.main_valid), 8'(got.main_valid));
      compare_field("main_handle", exp.main_handle, got.main_handle);
      compare_field("active_valid", 8'(exp.active_valid), 8'(got.active_valid));
      compare_field("active_handle", exp.active_handle, got.active_handle);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct = 19;
  int   recv_idle_pct = 49;

  handle_table_shadow shadow;

  pst_in_if  in_ch ();
  pst_out_if out_ch ();

  priority_sorted_handle_table u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  // Presents one request and returns once its transfer has taken place.
  task automatic send_request(input mode_t m, input logic [HANDLE_W-1:0] h,
                              input logic [PRI_W-1:0] p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.handle       <= h;
    in_ch.priority_req <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    shadow.accept_request(m, h, p);
  endtask

  // Switches at random between filling and draining phases so that the table often runs full and empty.
  task automatic run_random_phase(input int unsigned count);
    int unsigned         n;
    int unsigned         pick;
    int unsigned         insert_pct;
    int unsigned         remove_pct;
    int unsigned         held_pct;
    int unsigned         pool_base;
    mode_t               m;
    logic [HANDLE_W-1:0] h;
    logic [PRI_W-1:0]    p;
    insert_pct = 65;
    remove_pct = 15;
    pool_base  = 0;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        insert_pct = ($urandom_range(0, 1) == 1) ? 65 : 20;
        remove_pct = (insert_pct == 65) ? 15 : 60;
        pool_base  = $urandom_range(0, 232);
      end
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) m = MODE_INSERT;
      else if (pick < insert_pct + remove_pct) m = MODE_REMOVE;
      else if ($urandom_range(0, 1) == 1) m = MODE_ACTIVE;
      else m = MODE_MAIN;
      held_pct = (m == MODE_INSERT) ? 10 : 70;
      pick = $urandom_range(0, 99);
      if (pick < held_pct && shadow.held > 0)
        h = shadow.slot_handle[$urandom_range(0, shadow.held - 1)];
      else if (pick < held_pct + 50)
        h = HANDLE_W'(pool_base + $urandom_range(0, 23));
      else
        h = HANDLE_W'($urandom_range(0, 255));
      // Narrow priorities give plenty of ties, whose arrival order must be kept.
      if ($urandom_range(0, 1) == 1) p = PRI_W'($urandom_range(0, 3));
      else p = PRI_W'($urandom_range(0, 255));
      send_request(m, h, p);
    end
  endtask

  initial begin
    result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.status        = status_t'(out_ch.status);
        got.entry_count   = out_ch.entry_count;
        got.main_valid    = out_ch.main_valid;
        got.main_handle   = out_ch.main_handle;
        got.active_valid  = out_ch.active_valid;
        got.active_handle = out_ch.active_handle;
        shadow.check_result(got);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int i;
    shadow = new();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_INSERT;
    in_ch.handle       <= '0;
    in_ch.priority_req <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(MODE_REMOVE, 8'd5, 8'd0);
    send_request(MODE_INSERT, 8'd0, 8'd0);
    send_request(MODE_INSERT, 8'd255, 8'd255);
    send_request(MODE_INSERT, 8'd7, 8'd0);
    send_request(MODE_INSERT, 8'd0, 8'd100);
    // Active is not yet set and still reads as zero, so removing handle zero leaves it alone.
    send_request(MODE_REMOVE, 8'd0, 8'd0);
    send_request(MODE_ACTIVE, 8'd255, 8'd0);
    send_request(MODE_REMOVE, 8'd255, 8'd0);
    send_request(MODE_MAIN, 8'd128, 8'd0);
    for (i = 0; i < 15; i++) send_request(MODE_INSERT, HANDLE_W'(16 + i), PRI_W'((i * 53) % 256));
    send_request(MODE_INSERT, 8'd30, 8'd9);
    send_request(MODE_INSERT, 8'd7, 8'd1);

    run_random_phase(310);
    send_idle_pct = 49;
    recv_idle_pct = 19;
    run_random_phase(310);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(310);

    in_ch.valid <= 1'b0;
    while (shadow.pending_results.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
